// ----- sv/vup_pkg.sv -----
// shared types, constants and helper functions of the vector unpack engine
`default_nettype none

package vup_pkg;

    // destination space in quadwords, a power of two
    localparam int ADDR_SPACE_QW = 1024;
    localparam int ADDR_W        = $clog2(ADDR_SPACE_QW);

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int STRIDE_W = 2;
    localparam int PHASE_W  = 2;
    localparam int LANES    = 4;
    localparam int HELD_N   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] V3_LANE_THREE = 32'h0000_0080;
    localparam logic [ADDR_W-1:0] LIMIT_RESET   = ADDR_W'(328);

    typedef logic [WORD_W-1:0]              word_t;
    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic [HELD_N-1:0][WORD_W-1:0]  held_t;
    typedef logic [LANES-1:0][WORD_W-1:0]   quad_t;

    typedef enum logic [1:0] {
        FMT_V4_8  = 2'd0,
        FMT_V4_16 = 2'd1,
        FMT_V3_32 = 2'd2,
        FMT_V4_32 = 2'd3
    } fmt_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_LANE_ZERO  = 3'd0,
        CFG_ROW_LANE_ONE   = 3'd1,
        CFG_ROW_LANE_TWO   = 3'd2,
        CFG_ROW_LANE_THREE = 3'd3,
        CFG_ADDRESS_LIMIT  = 3'd4
    } cfg_idx_t;

    // one input item as held in the input register
    typedef struct packed {
        logic                cmd;
        logic [COUNT_W-1:0]  vector_count;
        addr_t               start_address;
        logic [1:0]          format;
        logic                zero_extend;
        logic                add_row;
        logic [STRIDE_W-1:0] write_stride;
        word_t               data_word;
    } item_t;

    // one quadword write as held in the result register
    typedef struct packed {
        addr_t write_address;
        quad_t lanes;
        logic  final_vector;
        logic  out_of_range;
    } result_t;

    // per-vector decode settings handed to the lane builder
    typedef struct packed {
        fmt_t fmt;
        logic zero_ext;
        logic row_mode;
    } lane_ctl_t;

    function automatic word_t ext8(input logic [7:0] b, input logic zero_ext);
        ext8 = {{(WORD_W-8){b[7] & ~zero_ext}}, b};
    endfunction

    function automatic word_t ext16(input logic [15:0] h, input logic zero_ext);
        ext16 = {{(WORD_W-16){h[15] & ~zero_ext}}, h};
    endfunction

endpackage

`default_nettype wire

// ----- sv/vup_stream_if.sv -----
// valid/ready channels carrying input items and quadword writes
`default_nettype none

interface vup_item_if import vup_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [COUNT_W-1:0]  vector_count;
    addr_t               start_address;
    logic [1:0]          format;
    logic                zero_extend;
    logic                add_row;
    logic [STRIDE_W-1:0] write_stride;
    word_t               data_word;

    modport source (
        output valid, cmd, vector_count, start_address, format,
               zero_extend, add_row, write_stride, data_word,
        input  ready
    );
    modport sink (
        input  valid, cmd, vector_count, start_address, format,
               zero_extend, add_row, write_stride, data_word,
        output ready
    );
endinterface

interface vup_result_if import vup_pkg::*; ();
    logic  valid;
    logic  ready;
    addr_t write_address;
    word_t lane_zero;
    word_t lane_one;
    word_t lane_two;
    word_t lane_three;
    logic  final_vector;
    logic  out_of_range;

    modport source (
        output valid, write_address, lane_zero, lane_one, lane_two, lane_three,
               final_vector, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, write_address, lane_zero, lane_one, lane_two, lane_three,
               final_vector, out_of_range,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/vup_lane_build.sv -----
// element extraction, extension and row addition for one finished vector
`default_nettype none

module vup_lane_build import vup_pkg::*; (
    input  var lane_ctl_t ctl,
    input  var held_t     held,
    input  var word_t     word,
    input  var quad_t     row,
    output quad_t         lanes
);

    quad_t base;

    always_comb
    begin
        unique case (ctl.fmt)
            FMT_V4_8:
            begin
                base[0] = ext8(word[7:0],   ctl.zero_ext);
                base[1] = ext8(word[15:8],  ctl.zero_ext);
                base[2] = ext8(word[23:16], ctl.zero_ext);
                base[3] = ext8(word[31:24], ctl.zero_ext);
            end
            FMT_V4_16:
            begin
                base[0] = ext16(held[0][15:0],  ctl.zero_ext);
                base[1] = ext16(held[0][31:16], ctl.zero_ext);
                base[2] = ext16(word[15:0],     ctl.zero_ext);
                base[3] = ext16(word[31:16],    ctl.zero_ext);
            end
            FMT_V3_32:
            begin
                base[0] = held[0];
                base[1] = held[1];
                base[2] = word;
                base[3] = '0;
            end
            FMT_V4_32:
            begin
                base[0] = held[0];
                base[1] = held[1];
                base[2] = held[2];
                base[3] = word;
            end
            default:
            begin
                base = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lanes[k] = base[k] + (ctl.row_mode ? row[k] : word_t'(0));
        end
        // v3 fourth lane is fixed regardless of row addition
        if (ctl.fmt == FMT_V3_32)
        begin
            lanes[3] = V3_LANE_THREE;
        end
    end

endmodule

`default_nettype wire

// ----- sv/vector_unpack_engine.sv -----
// vector unpack engine top level: input register, unpack state, result register
//
//  channel    dir  width           transfer means
//  item_ch    in   cmd+57 bits     start command or one 32-bit data word
//  result_ch  out  10+4x32+2 bits  one quadword write of a finished vector
//  cfg_*      in   3 + 32 bits     row register or address limit write
//
// one item per cycle sustained unless the result stalls; an item is registered
// in the input register and its result, if any, then in the result register
// v4-8 yields a result per word, v4-16 every 2nd, v3-32 every 3rd, v4-32 every 4th
// reset clears all control state, row registers to 0 and the address limit to 328
// a stalled result holds the input register, which still takes a transfer when
// the result register is being drained in the same cycle
`default_nettype none

module vector_unpack_engine import vup_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    vup_item_if.sink               item_ch,
    vup_result_if.source           result_ch,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire word_t             cfg_data
);

    // configuration registers
    quad_t row_reg;
    addr_t limit_reg;

    // input register stage
    logic  s1_valid_reg;
    item_t s1_item_reg;
    item_t item_in;

    // unpack state
    logic                active_reg;
    fmt_t                fmt_reg;
    logic                zext_reg;
    logic                row_mode_reg;
    logic [STRIDE_W-1:0] stride_reg;
    addr_t               addr_reg;
    logic [COUNT_W-1:0]  left_reg;
    logic [PHASE_W-1:0]  phase_reg;
    held_t               held_reg;

    // result register
    logic    res_valid_reg;
    result_t res_reg;

    logic               slot_free;
    logic               s1_fire;
    logic               is_start;
    logic               data_active;
    logic               gather;
    logic               finish;
    logic               res_load;
    logic [COUNT_W-1:0] left_dec;
    addr_t              addr_step;
    lane_ctl_t          lane_ctl;
    quad_t              lanes;

    // ---------------------------------------------------------------- handshake
    // input stage moves on when the result slot is empty or being drained
    assign slot_free     = !res_valid_reg || result_ch.ready;
    assign s1_fire       = s1_valid_reg && slot_free;
    assign item_ch.ready = !s1_valid_reg || s1_fire;

    assign item_in.cmd           = item_ch.cmd;
    assign item_in.vector_count  = item_ch.vector_count;
    assign item_in.start_address = item_ch.start_address;
    assign item_in.format        = item_ch.format;
    assign item_in.zero_extend   = item_ch.zero_extend;
    assign item_in.add_row       = item_ch.add_row;
    assign item_in.write_stride  = item_ch.write_stride;
    assign item_in.data_word     = item_ch.data_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ch.ready)
        begin
            s1_valid_reg <= item_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            s1_item_reg <= item_in;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_LANE_ZERO:  row_reg[0] <= cfg_data;
                CFG_ROW_LANE_ONE:   row_reg[1] <= cfg_data;
                CFG_ROW_LANE_TWO:   row_reg[2] <= cfg_data;
                CFG_ROW_LANE_THREE: row_reg[3] <= cfg_data;
                CFG_ADDRESS_LIMIT:  limit_reg  <= cfg_data[ADDR_W-1:0];
                default:            ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- item decode
    assign is_start    = s1_item_reg.cmd == CMD_START;
    // data words outside an unpack are dropped
    assign data_active = !is_start && active_reg;
    // earlier words of a vector go to the holding lanes
    assign gather      = data_active && (phase_reg < PHASE_W'(fmt_reg));
    assign finish      = data_active && !gather;
    assign res_load    = s1_fire && finish;

    assign left_dec  = left_reg - COUNT_W'(1);
    assign addr_step = addr_reg + ADDR_W'(stride_reg);

    // ---------------------------------------------------------------- unpack state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            fmt_reg      <= FMT_V4_8;
            zext_reg     <= 1'b0;
            row_mode_reg <= 1'b0;
            stride_reg   <= STRIDE_W'(1);
            addr_reg     <= '0;
            left_reg     <= '0;
            phase_reg    <= '0;
        end
        else if (s1_fire)
        begin
            if (is_start)
            begin
                // a start also abandons any unpack in progress
                active_reg   <= s1_item_reg.vector_count != '0;
                fmt_reg      <= fmt_t'(s1_item_reg.format);
                zext_reg     <= s1_item_reg.zero_extend;
                row_mode_reg <= s1_item_reg.add_row;
                stride_reg   <= s1_item_reg.write_stride;
                addr_reg     <= s1_item_reg.start_address;
                left_reg     <= s1_item_reg.vector_count;
                phase_reg    <= '0;
            end
            else if (gather)
            begin
                phase_reg <= phase_reg + PHASE_W'(1);
            end
            else if (finish)
            begin
                left_reg   <= left_dec;
                addr_reg   <= addr_step;
                phase_reg  <= '0;
                active_reg <= left_dec != '0;
            end
        end
    end

    // holding lanes, always written before they are read within a vector
    always_ff @(posedge clk)
    begin
        if (s1_fire && gather)
        begin
            held_reg[phase_reg] <= s1_item_reg.data_word;
        end
    end

    // ---------------------------------------------------------------- lane build
    assign lane_ctl.fmt      = fmt_reg;
    assign lane_ctl.zero_ext = zext_reg;
    assign lane_ctl.row_mode = row_mode_reg;

    vup_lane_build u_lane_build (
        .ctl   (lane_ctl),
        .held  (held_reg),
        .word  (s1_item_reg.data_word),
        .row   (row_reg),
        .lanes (lanes)
    );

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.write_address <= addr_reg;
            res_reg.lanes         <= lanes;
            res_reg.final_vector  <= left_dec == '0;
            res_reg.out_of_range  <= addr_reg > limit_reg;
        end
    end

    assign result_ch.valid         = res_valid_reg;
    assign result_ch.write_address = res_reg.write_address;
    assign result_ch.lane_zero     = res_reg.lanes[0];
    assign result_ch.lane_one      = res_reg.lanes[1];
    assign result_ch.lane_two      = res_reg.lanes[2];
    assign result_ch.lane_three    = res_reg.lanes[3];
    assign result_ch.final_vector  = res_reg.final_vector;
    assign result_ch.out_of_range  = res_reg.out_of_range;

    // ---------------------------------------------------------------- checks
    // an unpack is running exactly while vectors remain
    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (left_reg != '0))
        else $error("active flag disagrees with remaining vector count");

    // the gather phase never reaches the word count of the format
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (phase_reg <= PHASE_W'(fmt_reg)))
        else $error("gather phase beyond format word count");

    // the last vector ends the unpack
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && left_dec == '0) |=> !active_reg)
        else $error("unpack still active after final vector");

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || result_ch.ready))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ----- tb/vup_write_checker.sv -----
// checker for the vector unpack engine: predicts each quadword write and compares it
`timescale 1ns / 100ps

module vup_write_checker import vup_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    vup_item_if                  item_ch,
    vup_result_if                result_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data,
    output int                   writes_waiting,
    output int                   fail_count
);

    typedef struct packed {
        addr_t address;
        quad_t lanes;
        logic  last;
        logic  oor;
    } quad_write_t;

    // register copies
    word_t               row [LANES];
    addr_t               limit;

    // unpack state
    logic                busy;
    fmt_t                fmt;
    logic                zext;
    logic                row_mode;
    logic [STRIDE_W-1:0] stride;
    addr_t               next_addr;
    logic [COUNT_W-1:0]  left;
    logic [PHASE_W-1:0]  phase;
    word_t               held [HELD_N];

    quad_write_t         writes_due [$];
    int                  errors = 0;

    assign fail_count = errors;

    // byte or halfword element to a 32-bit lane
    function automatic word_t widen(input logic [15:0] v, input logic is_half, input logic zx);
        logic fill;
        fill = !zx && (is_half ? v[15] : v[7]);
        if (is_half)
            return {{16{fill}}, v};
        return {{24{fill}}, v[7:0]};
    endfunction

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // one accepted item through the unpack state
    task automatic unpack_item();
        word_t       word;
        word_t       lane [LANES];
        quad_write_t w;
        if (cmd_t'(item_ch.cmd) == CMD_START) begin
            left      = item_ch.vector_count;
            next_addr = item_ch.start_address;
            fmt       = fmt_t'(item_ch.format);
            zext      = item_ch.zero_extend;
            row_mode  = item_ch.add_row;
            stride    = item_ch.write_stride;
            phase     = '0;
            busy      = (item_ch.vector_count != 0);
            return;
        end
        if (!busy)
            return;
        word = item_ch.data_word;
        // earlier words of the vector are held
        if (phase < fmt) begin
            held[phase] = word;
            phase       = phase + 1'b1;
            return;
        end
        case (fmt)
            FMT_V4_8: begin
                for (int k = 0; k < LANES; k++)
                    lane[k] = widen(16'(word[8*k +: 8]), 1'b0, zext);
            end
            FMT_V4_16: begin
                lane[0] = widen(held[0][15:0], 1'b1, zext);
                lane[1] = widen(held[0][31:16], 1'b1, zext);
                lane[2] = widen(word[15:0], 1'b1, zext);
                lane[3] = widen(word[31:16], 1'b1, zext);
            end
            FMT_V3_32: begin
                lane[0] = held[0];
                lane[1] = held[1];
                lane[2] = word;
                lane[3] = '0;
            end
            default: begin
                lane[0] = held[0];
                lane[1] = held[1];
                lane[2] = held[2];
                lane[3] = word;
            end
        endcase
        if (row_mode)
            for (int k = 0; k < LANES; k++)
                lane[k] = lane[k] + row[k];
        if (fmt == FMT_V3_32)
            lane[3] = V3_LANE_THREE;
        left = left - 1'b1;
        w.address = next_addr;
        for (int k = 0; k < LANES; k++)
            w.lanes[k] = lane[k];
        w.last = (left == 0);
        w.oor  = (next_addr > limit);
        writes_due.push_back(w);
        next_addr = addr_t'((int'(next_addr) + int'(stride)) % ADDR_SPACE_QW);
        phase     = '0;
        if (left == 0)
            busy = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        quad_write_t w;
        if (!rst_n) begin
            for (int k = 0; k < LANES; k++)
                row[k] = '0;
            limit     = LIMIT_RESET;
            busy      = 1'b0;
            fmt       = FMT_V4_8;
            zext      = 1'b0;
            row_mode  = 1'b0;
            stride    = STRIDE_W'(1);
            next_addr = '0;
            left      = '0;
            phase     = '0;
            writes_due.delete();
            writes_waiting <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROW_LANE_ZERO, CFG_ROW_LANE_ONE,
                    CFG_ROW_LANE_TWO, CFG_ROW_LANE_THREE: row[cfg_index[1:0]] = cfg_data;
                    CFG_ADDRESS_LIMIT: limit = cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready) begin
                if (writes_due.size() == 0) begin
                    $error("quadword write to 0x%0h with none expected",
                           result_ch.write_address);
                    errors++;
                end else begin
                    w = writes_due.pop_front();
                    check_field("write_address", word_t'(w.address),
                                word_t'(result_ch.write_address));
                    check_field("lane_zero", w.lanes[0], result_ch.lane_zero);
                    check_field("lane_one", w.lanes[1], result_ch.lane_one);
                    check_field("lane_two", w.lanes[2], result_ch.lane_two);
                    check_field("lane_three", w.lanes[3], result_ch.lane_three);
                    check_field("final_vector", word_t'(w.last),
                                word_t'(result_ch.final_vector));
                    check_field("out_of_range", word_t'(w.oor),
                                word_t'(result_ch.out_of_range));
                end
            end
            if (item_ch.valid && item_ch.ready)
                unpack_item();
            writes_waiting <= writes_due.size();
        end
    end

endmodule

// ----- tb/vector_unpack_engine_tb.sv -----
// testbench top for the vector unpack engine: stimulus, flow control and verdict
`timescale 1ns / 100ps

module vector_unpack_engine_tb;
    import vup_pkg::*;

    // clock and a single reset at the start of the run
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // register write port
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;

    int    writes_waiting;
    int    fail_count;
    int    items_sent;
    addr_t lim_now;        // address limit currently programmed
    logic  src_gaps;       // sender idles in bursts when set
    logic  sink_stalls;    // receiver stalls in bursts when set

    vup_item_if   item_ch ();
    vup_result_if result_ch ();

    vector_unpack_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vup_write_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_ch        (item_ch),
        .result_ch      (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .writes_waiting (writes_waiting),
        .fail_count     (fail_count)
    );

    always #5 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: ready drops at random for a burst of random length while stalls are enabled
    initial
    begin : drain_side
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 11) == 0)
            begin
                hold = $urandom_range(1, 17);
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // one input transfer, optionally preceded by an idle burst
    task automatic send(input cmd_t c, input logic [COUNT_W-1:0] count, input addr_t addr,
                        input fmt_t f, input logic zx, input logic ar,
                        input logic [STRIDE_W-1:0] stride, input word_t word);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= c;
        item_ch.vector_count  <= count;
        item_ch.start_address <= addr;
        item_ch.format        <= f;
        item_ch.zero_extend   <= zx;
        item_ch.add_row       <= ar;
        item_ch.write_stride  <= stride;
        item_ch.data_word     <= word;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // start command, data word field left random
    task automatic start(input logic [COUNT_W-1:0] count, input addr_t addr, input fmt_t f,
                         input logic zx, input logic ar, input logic [STRIDE_W-1:0] stride);
        send(CMD_START, count, addr, f, zx, ar, stride, $urandom);
    endtask

    // data word, start-only fields left random
    task automatic data(input word_t word);
        send(CMD_DATA, COUNT_W'($urandom), ADDR_W'($urandom), fmt_t'($urandom_range(0, 3)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), STRIDE_W'($urandom), word);
    endtask

    // extremes of the element encodings mixed with plain random words
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8080_8080;
            3: return 32'h7F7F_7F7F;
            4: return 32'h8000_7FFF;
            default: return $urandom;
        endcase
    endfunction

    // hold the sender off until every quadword write is out, plus pipeline slack
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (writes_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    // writes all five registers back to back, only while the engine is idle
    task automatic program_regs(input word_t r0, input word_t r1, input word_t r2,
                                input word_t r3, input word_t lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_LANE_ZERO;
        cfg_data  <= r0;
        @(posedge clk);
        cfg_index <= CFG_ROW_LANE_ONE;
        cfg_data  <= r1;
        @(posedge clk);
        cfg_index <= CFG_ROW_LANE_TWO;
        cfg_data  <= r2;
        @(posedge clk);
        cfg_index <= CFG_ROW_LANE_THREE;
        cfg_data  <= r3;
        @(posedge clk);
        cfg_index <= CFG_ADDRESS_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_now = lim[ADDR_W-1:0];
    endtask

    task automatic directed_cases();
        // zero count stays idle, so the following word is dropped
        start(0, 10, FMT_V4_8, 1'b0, 1'b0, 1);
        data(32'hDEAD_BEEF);
        // v4-8 sign extension, first write past the limit, address wraps to 0
        start(2, 1023, FMT_V4_8, 1'b0, 1'b0, 1);
        data(32'h80FF_7F01);
        data(32'h0000_0000);
        // count exhausted: word dropped
        data(32'h1234_5678);
        // v4-16 zero extension, address exactly at the limit, row add with zero rows
        start(1, 328, FMT_V4_16, 1'b1, 1'b1, 3);
        data(32'h8000_FFFF);
        data(32'h7FFF_8001);
        // v3-32 with stride 0, one past the limit
        start(1, 329, FMT_V3_32, 1'b0, 1'b0, 0);
        data(32'h0000_0001);
        data(32'hFFFF_FFFF);
        data(32'h8000_0000);
        // v4-32 broken off by a restart with a vector partly gathered
        start(2, 0, FMT_V4_32, 1'b0, 1'b0, 2);
        data(32'h1111_1111);
        data(32'h2222_2222);
        data(32'h3333_3333);
        start(1, 5, FMT_V4_8, 1'b1, 1'b0, 1);
        data(32'hFFFF_FFFF);

        // extreme rows, limit 0 written with junk upper bits
        settle();
        program_regs(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FC00);
        // row add wraps, v3-32 lane three stays fixed
        start(1, 0, FMT_V3_32, 1'b0, 1'b1, 2);
        data(32'h0000_0001);
        data(32'hFFFF_FFFF);
        data(32'h8000_0000);
        start(1, 1, FMT_V4_16, 1'b0, 1'b1, 1);
        data(32'h8000_7FFF);
        data(32'hFFFF_0000);
    endtask

    // mostly well-formed unpacks with random content, some stray and broken traffic
    task automatic random_unpack();
        fmt_t                f;
        logic [COUNT_W-1:0]  count;
        logic [STRIDE_W-1:0] stride;
        addr_t               addr;
        int                  pick;
        int                  words;
        // pressure: sometimes let every outstanding write drain first
        if ($urandom_range(0, 39) == 0)
            settle();
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            data(pick_word());
            return;
        end
        if (pick < 6)
        begin
            start(COUNT_W'($urandom), ADDR_W'($urandom), fmt_t'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), STRIDE_W'($urandom));
            return;
        end
        f    = fmt_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 2)
            count = 0;
        else if (pick < 5)
            count = COUNT_W'($urandom_range(257, 511));
        else if (pick < 8)
            count = COUNT_W'($urandom_range(7, 40));
        else
            count = COUNT_W'($urandom_range(1, 6));
        // odd strides now and then
        if ($urandom_range(0, 9) < 8)
            stride = STRIDE_W'($urandom_range(1, 2));
        else
            stride = $urandom_range(0, 1) ? 2'd0 : 2'd3;
        // addresses near the top of the space and near the limit
        case ($urandom_range(0, 3))
            0: addr = 10'd1023 - ADDR_W'($urandom_range(0, 8));
            1: addr = lim_now + ADDR_W'($urandom_range(0, 4)) - 10'd2;
            default: addr = ADDR_W'($urandom);
        endcase
        start(count, addr, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), stride);
        words = int'(count) * (int'(f) + 1);
        // large counts are cut short and abandoned by the next start
        if (count > 40)
            words = $urandom_range(0, 30);
        else if ($urandom_range(0, 24) == 0)
            words = $urandom_range(0, words);
        for (int i = 0; i < words; i++)
            data(pick_word());
        // trailing word, dropped once the count is used up
        if ($urandom_range(0, 9) == 0)
            data(pick_word());
    endtask

    initial
    begin : stimulus
        int quota;
        int waited;
        // every input known from time zero
        item_ch.valid         = 1'b0;
        item_ch.cmd           = CMD_START;
        item_ch.vector_count  = '0;
        item_ch.start_address = '0;
        item_ch.format        = FMT_V4_8;
        item_ch.zero_extend   = 1'b0;
        item_ch.add_row       = 1'b0;
        item_ch.write_stride  = '0;
        item_ch.data_word     = '0;
        result_ch.ready       = 1'b1;
        cfg_we                = 1'b0;
        cfg_index             = CFG_ROW_LANE_ZERO;
        cfg_data              = '0;
        src_gaps              = 1'b0;
        sink_stalls           = 1'b0;
        items_sent            = 0;
        lim_now               = LIMIT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs first, starting on the reset register values
        directed_cases();

        // random phases, each on its own register setting
        for (int phase_n = 0; phase_n < 8; phase_n++)
        begin
            settle();
            case (phase_n)
                0: program_regs('0, '0, '0, '0, 32'd1023);
                1: program_regs('1, '1, '1, '1, 32'd0);
                2: program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FF80,
                                word_t'(LIMIT_RESET));
                default: program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            // no idling by the sender and no receiver stalls in phases 3 and 7
            src_gaps = (phase_n != 3) && (phase_n != 7);
            sink_stalls <= (phase_n != 3) && (phase_n != 7);
            quota = items_sent + 250;
            while (items_sent < quota)
                random_unpack();
        end

        // drain with a limit, then allow for the pipeline
        item_ch.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (writes_waiting != 0 && waited < 100000);
        repeat (8) @(posedge clk);
        if (writes_waiting != 0)
            $error("%0d quadword writes never arrived", writes_waiting);
        if (fail_count == 0 && writes_waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
